/* hdl/vne_pkg.sv */
// ----------------------------------------------------------------------------
// vne_pkg
// Types, codes and offset tables shared by the voxel neighbour enumerator.
// ----------------------------------------------------------------------------
`default_nettype none

package vne_pkg;

   // field widths fixed by the interface
   localparam int IDX_BITS       = 12;
   localparam int DIM_BITS       = 5;
   localparam int RANGE_BITS     = 16;
   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 16;

   // derived geometry widths
   localparam int DXY_BITS   = 2 * DIM_BITS;
   localparam int TOTAL_BITS = 3 * DIM_BITS;
   // neighbour index before truncation: centre plus at most one plane and row
   localparam int NIDX_BITS  = 14;

   // parameter defaults
   localparam int MAX_VOXELS_DEF = 4096;
   localparam int VALUE_BITS_DEF = 16;

   // neighbour slots walked per query
   localparam int SLOT_COUNT = 26;
   localparam int SLOT_BITS  = 5;

   // request kinds
   typedef enum logic [1:0] {
      CMD_WRITE   = 2'd0,
      CMD_ALL     = 2'd1,
      CMD_SMALLER = 2'd2,
      CMD_GREATER = 2'd3
   } cmd_type;

   // connectivity modes
   typedef enum logic [1:0] {
      CONN_FACE      = 2'd0,
      CONN_EDGE      = 2'd1,
      CONN_CORNER    = 2'd2,
      CONN_EIGHT_TWO = 2'd3
   } conn_type;

   // register indexes
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_X        = 3'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_Y        = 3'd1;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_DIM_Z        = 3'd2;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CONNECTIVITY = 3'd3;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_SLICES_ONLY  = 3'd4;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_MIN    = 3'd5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_RANGE_MAX    = 3'd6;

   // signed 2-bit offset codes
   localparam logic [1:0] OFF_M1 = 2'b11;
   localparam logic [1:0] OFF_Z  = 2'b00;
   localparam logic [1:0] OFF_P1 = 2'b01;

   // configuration registers
   typedef struct packed {
      logic [DIM_BITS-1:0]   dim_x;
      logic [DIM_BITS-1:0]   dim_y;
      logic [DIM_BITS-1:0]   dim_z;
      conn_type              connectivity;
      logic                  slices_only;
      logic [RANGE_BITS-1:0] range_min;
      logic [RANGE_BITS-1:0] range_max;
   } cfg_type;

   // classified request passed from front to back
   typedef struct packed {
      cmd_type             cmd;
      logic                ok;
      logic [DIM_BITS-1:0] cx;
      logic [DIM_BITS-1:0] cy;
      logic [DIM_BITS-1:0] cz;
   } q_ctrl_type;

   // neighbour offset
   typedef struct packed {
      logic [1:0] ox;
      logic [1:0] oy;
      logic [1:0] oz;
   } offset_type;

   typedef enum logic [1:0] {
      F_IDLE,
      F_DIV_X,
      F_DIV_Y,
      F_PUSH
   } f_state_type;

   typedef enum logic [2:0] {
      B_IDLE,
      B_CLATCH,
      B_WALK,
      B_DRAIN,
      B_FINISH
   } b_state_type;

   // offset of a neighbour slot in walk order
   function automatic offset_type slot_offset(input logic [SLOT_BITS-1:0] slot);
      offset_type            off;
      logic [SLOT_BITS-1:0]  base;
      logic [1:0]            k;
      logic                  is_face;
      logic                  is_diag;
      off     = '0;
      base    = '0;
      is_face = 1'b0;
      is_diag = 1'b0;
      case (slot) inside
         [5'd0:5'd3]: begin
            base = 5'd0;  is_face = 1'b1; off.oz = OFF_Z;
         end
         [5'd4:5'd7]: begin
            base = 5'd4;  is_diag = 1'b1; off.oz = OFF_Z;
         end
         5'd8: begin
            off.oz = OFF_M1;
         end
         5'd9: begin
            off.oz = OFF_P1;
         end
         [5'd10:5'd13]: begin
            base = 5'd10; is_face = 1'b1; off.oz = OFF_M1;
         end
         [5'd14:5'd17]: begin
            base = 5'd14; is_face = 1'b1; off.oz = OFF_P1;
         end
         [5'd18:5'd21]: begin
            base = 5'd18; is_diag = 1'b1; off.oz = OFF_M1;
         end
         [5'd22:5'd25]: begin
            base = 5'd22; is_diag = 1'b1; off.oz = OFF_P1;
         end
         default: begin
            off = '0;
         end
      endcase
      k = 2'(slot - base);
      if (is_face) begin
         case (k)
            2'd0:    begin off.ox = OFF_Z;  off.oy = OFF_M1; end
            2'd1:    begin off.ox = OFF_M1; off.oy = OFF_Z;  end
            2'd2:    begin off.ox = OFF_P1; off.oy = OFF_Z;  end
            default: begin off.ox = OFF_Z;  off.oy = OFF_P1; end
         endcase
      end
      if (is_diag) begin
         off.ox = k[0] ? OFF_P1 : OFF_M1;
         off.oy = k[1] ? OFF_P1 : OFF_M1;
      end
      return off;
   endfunction

   // whether a slot takes part for the given mode
   function automatic logic slot_enable(input logic [SLOT_BITS-1:0] slot,
                                        input conn_type conn,
                                        input logic slices);
      logic edge_up;
      logic en;
      edge_up = (conn == CONN_EDGE) || (conn == CONN_CORNER);
      case (slot) inside
         [5'd0:5'd3]:   en = slices ? edge_up : 1'b1;
         [5'd4:5'd7]:   en = slices ? (conn == CONN_CORNER) : (conn != CONN_FACE);
         [5'd8:5'd9]:   en = !slices;
         [5'd10:5'd17]: en = !slices && edge_up;
         [5'd18:5'd25]: en = !slices && (conn == CONN_CORNER);
         default:       en = 1'b0;
      endcase
      return en;
   endfunction

endpackage

`default_nettype wire

/* hdl/vne_front.sv */
// ----------------------------------------------------------------------------
// vne_front
// Accepts requests and splits a query's linear index into x, y and z with
// a shared one-bit-a-cycle divider, then queues the classified request.
// ----------------------------------------------------------------------------
`default_nettype none

module vne_front
   import vne_pkg::*;
#(
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   parameter int MAX_VOXELS = MAX_VOXELS_DEF
)
(
   input  wire                     clock,
   input  wire                     reset,
   input  wire                     in_valid,
   output logic                    in_ready,
   input  cmd_type                 in_cmd,
   input  wire  [IDX_BITS-1:0]     in_index,
   input  wire  [VALUE_BITS-1:0]   in_value,
   input  cfg_type                 cfg,
   input  wire  [TOTAL_BITS-1:0]   total,
   output logic                    push_valid,
   input  wire                     push_ready,
   output q_ctrl_type              push_ctrl,
   output logic [IDX_BITS-1:0]     push_index,
   output logic [VALUE_BITS-1:0]   push_value
);

   localparam int CNT_BITS = $clog2(IDX_BITS);

   f_state_type               state_ff, state_in;
   cmd_type                   cmd_ff, cmd_in;
   logic [IDX_BITS-1:0]       idx_ff, idx_in;
   logic [VALUE_BITS-1:0]     value_ff, value_in;
   logic [IDX_BITS-1:0]       div_n_ff, div_n_in;
   logic [DIM_BITS-1:0]       div_r_ff, div_r_in;
   logic [CNT_BITS-1:0]       cnt_ff, cnt_in;
   logic [DIM_BITS-1:0]       cx_ff, cx_in;
   logic [DIM_BITS-1:0]       cy_ff, cy_in;
   logic [DIM_BITS-1:0]       cz_ff, cz_in;

   logic                      take;
   logic                      cnt_last;
   logic [DIM_BITS-1:0]       divisor;
   logic [DIM_BITS:0]         rem_t;
   logic                      ge;
   logic [DIM_BITS-1:0]       rem_nx;
   logic [IDX_BITS-1:0]       quo_nx;
   logic                      centre_ok;

   // restoring divider step
   always_comb begin
      divisor  = (state_ff == F_DIV_X) ? cfg.dim_x : cfg.dim_y;
      rem_t    = {div_r_ff, div_n_ff[IDX_BITS-1]};
      ge       = rem_t >= {1'b0, divisor};
      rem_nx   = ge ? DIM_BITS'(rem_t - {1'b0, divisor}) : rem_t[DIM_BITS-1:0];
      quo_nx   = {div_n_ff[IDX_BITS-2:0], ge};
      cnt_last = cnt_ff == CNT_BITS'(IDX_BITS - 1);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         F_IDLE: begin
            if (in_valid) begin
               state_in = (in_cmd == CMD_WRITE) ? F_PUSH : F_DIV_X;
            end
         end
         F_DIV_X: begin
            if (cnt_last) state_in = F_DIV_Y;
         end
         F_DIV_Y: begin
            if (cnt_last) state_in = F_PUSH;
         end
         F_PUSH: begin
            if (push_ready) state_in = F_IDLE;
         end
         default: state_in = F_IDLE;
      endcase
   end

   // handshake outputs
   always_comb begin
      in_ready   = state_ff == F_IDLE;
      push_valid = state_ff == F_PUSH;
   end

   // centre must lie in a volume that fits the store
   always_comb begin
      centre_ok = (total != '0)
               && ({17'b0, total} <= 32'(MAX_VOXELS))
               && ({3'b0, idx_ff} < total);
      push_ctrl.cmd = cmd_ff;
      push_ctrl.ok  = centre_ok;
      push_ctrl.cx  = cx_ff;
      push_ctrl.cy  = cy_ff;
      push_ctrl.cz  = cz_ff;
      push_index    = idx_ff;
      push_value    = value_ff;
   end

   // datapath
   always_comb begin
      take     = in_valid && in_ready;
      cmd_in   = cmd_ff;
      idx_in   = idx_ff;
      value_in = value_ff;
      div_n_in = div_n_ff;
      div_r_in = div_r_ff;
      cnt_in   = cnt_ff;
      cx_in    = cx_ff;
      cy_in    = cy_ff;
      cz_in    = cz_ff;
      if (take) begin
         cmd_in   = in_cmd;
         idx_in   = in_index;
         value_in = in_value;
         div_n_in = in_index;
         div_r_in = '0;
         cnt_in   = '0;
      end else if (state_ff == F_DIV_X || state_ff == F_DIV_Y) begin
         div_n_in = quo_nx;
         div_r_in = rem_nx;
         cnt_in   = cnt_ff + 1'b1;
         if (cnt_last) begin
            div_r_in = '0;
            cnt_in   = '0;
            if (state_ff == F_DIV_X) begin
               cx_in = rem_nx;
            end else begin
               cy_in = rem_nx;
               cz_in = quo_nx[DIM_BITS-1:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
      end else begin
         state_ff <= state_in;
      end
      cmd_ff   <= cmd_in;
      idx_ff   <= idx_in;
      value_ff <= value_in;
      div_n_ff <= div_n_in;
      div_r_ff <= div_r_in;
      cnt_ff   <= cnt_in;
      cx_ff    <= cx_in;
      cy_ff    <= cy_in;
      cz_ff    <= cz_in;
   end

endmodule

`default_nettype wire

/* hdl/vne_fifo.sv */
// ----------------------------------------------------------------------------
// vne_fifo
// Two-entry queue between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module vne_fifo
   import vne_pkg::*;
#(
   parameter int WIDTH = 8
)
(
   input  wire              clock,
   input  wire              reset,
   input  wire              wr_valid,
   output logic             wr_ready,
   input  wire  [WIDTH-1:0] wr_data,
   output logic             rd_valid,
   input  wire              rd_ready,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] entry_ff [2];
   logic             wr_ptr_ff, wr_ptr_in;
   logic             rd_ptr_ff, rd_ptr_in;
   logic [1:0]       count_ff, count_in;
   logic             do_wr;
   logic             do_rd;

   // pointer and fill bookkeeping
   always_comb begin
      wr_ready  = count_ff != 2'd2;
      rd_valid  = count_ff != 2'd0;
      rd_data   = entry_ff[rd_ptr_ff];
      do_wr     = wr_valid && wr_ready;
      do_rd     = rd_valid && rd_ready;
      wr_ptr_in = do_wr ? !wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = do_rd ? !rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, do_wr} - {1'b0, do_rd};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
      if (do_wr) begin
         entry_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

`default_nettype wire

/* hdl/vne_back.sv */
// ----------------------------------------------------------------------------
// vne_back
// Holds the voxel store, carries out writes and walks the neighbour slots
// of a query, one store read per enabled in-bounds slot, holding back one result to mark last.
// ----------------------------------------------------------------------------
`default_nettype none

module vne_back
   import vne_pkg::*;
#(
   parameter int MAX_VOXELS = MAX_VOXELS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF
)
(
   input  wire                    clock,
   input  wire                    reset,
   input  wire                    pop_valid,
   output logic                   pop_ready,
   input  q_ctrl_type             pop_ctrl,
   input  wire  [IDX_BITS-1:0]    pop_index,
   input  wire  [VALUE_BITS-1:0]  pop_value,
   input  cfg_type                cfg,
   input  wire  [DXY_BITS-1:0]    dxy,
   output logic                   out_valid,
   input  wire                    out_ready,
   output logic [IDX_BITS-1:0]    out_index,
   output logic [VALUE_BITS-1:0]  out_value,
   output logic                   out_none,
   output logic                   out_last
);

   localparam int AW    = $clog2(MAX_VOXELS);
   localparam int CMP_W = (VALUE_BITS > RANGE_BITS) ? VALUE_BITS : RANGE_BITS;
   localparam logic [VALUE_BITS-1:0] VAL_KEEP =
      {VALUE_BITS{1'b1}} >> ((VALUE_BITS > RANGE_BITS) ? (VALUE_BITS - RANGE_BITS) : 0);

   // voxel store
   logic [VALUE_BITS-1:0]  mem [MAX_VOXELS];

   b_state_type            state_ff, state_in;
   q_ctrl_type             q_ctrl_ff, q_ctrl_in;
   logic [IDX_BITS-1:0]    centre_idx_ff, centre_idx_in;
   logic [VALUE_BITS-1:0]  centre_val_ff, centre_val_in;
   logic [SLOT_BITS-1:0]   slot_ff, slot_in;
   logic                   b_valid_ff, b_valid_in;
   logic [NIDX_BITS-1:0]   b_idx_ff, b_idx_in;
   logic [VALUE_BITS-1:0]  rd_data_ff;
   logic                   pend_valid_ff, pend_valid_in;
   logic [IDX_BITS-1:0]    pend_idx_ff, pend_idx_in;
   logic [VALUE_BITS-1:0]  pend_val_ff, pend_val_in;
   logic                   rsp_valid_ff, rsp_valid_in;
   logic [IDX_BITS-1:0]    rsp_idx_ff, rsp_idx_in;
   logic [VALUE_BITS-1:0]  rsp_val_ff, rsp_val_in;
   logic                   rsp_none_ff, rsp_none_in;
   logic                   rsp_last_ff, rsp_last_in;

   logic                   take;
   logic                   wr_en;
   logic                   rd_en;
   logic [AW-1:0]          rd_addr;
   logic                   out_free;
   offset_type             off;
   logic                   slot_en;
   logic [6:0]             nx, ny, nz;
   logic                   inb;
   logic                   hit;
   logic [14:0]            ty, tz;
   logic [14:0]            nidx_s;
   logic [NIDX_BITS-1:0]   nidx;
   logic [CMP_W-1:0]       cmp_val, cmp_min, cmp_max;
   logic                   in_range, below, above, b_pass;
   logic                   b_consume;
   logic                   advance;
   logic                   last_slot;
   logic                   shift_load;
   logic                   finish_load;

   // candidate neighbour for the current slot
   always_comb begin
      off     = slot_offset(slot_ff);
      slot_en = slot_enable(slot_ff, cfg.connectivity, cfg.slices_only);
      nx  = {2'b00, q_ctrl_ff.cx} + {{5{off.ox[1]}}, off.ox};
      ny  = {2'b00, q_ctrl_ff.cy} + {{5{off.oy[1]}}, off.oy};
      nz  = {2'b00, q_ctrl_ff.cz} + {{5{off.oz[1]}}, off.oz};
      inb = !nx[6] && (nx[5:0] < {1'b0, cfg.dim_x})
         && !ny[6] && (ny[5:0] < {1'b0, cfg.dim_y})
         && !nz[6] && (nz[5:0] < {1'b0, cfg.dim_z});
      hit = slot_en && inb;
      // index moves by one, one row or one plane per offset step
      case (off.oy)
         OFF_P1:  ty = {10'b0, cfg.dim_x};
         OFF_M1:  ty = 15'd0 - {10'b0, cfg.dim_x};
         default: ty = '0;
      endcase
      case (off.oz)
         OFF_P1:  tz = {5'b0, dxy};
         OFF_M1:  tz = 15'd0 - {5'b0, dxy};
         default: tz = '0;
      endcase
      nidx_s    = {3'b0, centre_idx_ff} + {{13{off.ox[1]}}, off.ox} + ty + tz;
      nidx      = nidx_s[NIDX_BITS-1:0];
      last_slot = slot_ff == SLOT_BITS'(SLOT_COUNT - 1);
   end

   // filter on the value read for the stage b neighbour
   always_comb begin
      cmp_val  = CMP_W'(rd_data_ff);
      cmp_min  = CMP_W'(cfg.range_min);
      cmp_max  = CMP_W'(cfg.range_max);
      in_range = (cmp_val >= cmp_min) && (cmp_val <= cmp_max);
      below    = (rd_data_ff < centre_val_ff)
              || ((rd_data_ff == centre_val_ff) && (b_idx_ff < {2'b0, centre_idx_ff}));
      above    = (rd_data_ff > centre_val_ff)
              || ((rd_data_ff == centre_val_ff) && (b_idx_ff > {2'b0, centre_idx_ff}));
      b_pass   = (q_ctrl_ff.cmd == CMD_ALL)
              || (in_range && (((q_ctrl_ff.cmd == CMD_SMALLER) && below)
                            || ((q_ctrl_ff.cmd == CMD_GREATER) && above)));
      out_free  = !rsp_valid_ff || out_ready;
      b_consume = b_valid_ff && (!b_pass || !pend_valid_ff || out_free);
      advance   = (state_ff == B_WALK) && (!b_valid_ff || b_consume);
   end

   // next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: begin
            if (pop_valid && pop_ctrl.cmd != CMD_WRITE) begin
               state_in = pop_ctrl.ok ? B_CLATCH : B_FINISH;
            end
         end
         B_CLATCH: state_in = B_WALK;
         B_WALK: begin
            if (advance && last_slot) state_in = B_DRAIN;
         end
         B_DRAIN: begin
            if (!b_valid_ff) state_in = B_FINISH;
         end
         B_FINISH: begin
            if (out_free) state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      pop_ready   = state_ff == B_IDLE;
      take        = pop_valid && pop_ready;
      wr_en       = take && (pop_ctrl.cmd == CMD_WRITE)
                 && ({20'b0, pop_index} < 32'(MAX_VOXELS));
      rd_en       = (take && (pop_ctrl.cmd != CMD_WRITE)) || (advance && hit);
      rd_addr     = (state_ff == B_IDLE) ? AW'(pop_index) : AW'(nidx);
      shift_load  = b_consume && b_pass && pend_valid_ff;
      finish_load = (state_ff == B_FINISH) && out_free;
   end

   // datapath
   always_comb begin
      q_ctrl_in     = take ? pop_ctrl : q_ctrl_ff;
      centre_idx_in = take ? pop_index : centre_idx_ff;
      centre_val_in = (state_ff == B_CLATCH) ? rd_data_ff : centre_val_ff;
      slot_in       = slot_ff;
      if (state_ff == B_CLATCH) begin
         slot_in = '0;
      end else if (advance) begin
         slot_in = slot_ff + 1'b1;
      end
      b_valid_in = advance ? hit : (b_valid_ff && !b_consume);
      b_idx_in   = (advance && hit) ? nidx : b_idx_ff;

      // one result held back until the next one or the end of the walk
      pend_valid_in = pend_valid_ff;
      pend_idx_in   = pend_idx_ff;
      pend_val_in   = pend_val_ff;
      if (b_consume && b_pass) begin
         pend_valid_in = 1'b1;
         pend_idx_in   = b_idx_ff[IDX_BITS-1:0];
         pend_val_in   = rd_data_ff;
      end else if (finish_load) begin
         pend_valid_in = 1'b0;
      end

      // output register
      rsp_idx_in  = rsp_idx_ff;
      rsp_val_in  = rsp_val_ff;
      rsp_none_in = rsp_none_ff;
      rsp_last_in = rsp_last_ff;
      if (shift_load) begin
         rsp_idx_in  = pend_idx_ff;
         rsp_val_in  = pend_val_ff;
         rsp_none_in = 1'b0;
         rsp_last_in = 1'b0;
      end else if (finish_load) begin
         rsp_idx_in  = pend_valid_ff ? pend_idx_ff : '0;
         rsp_val_in  = pend_valid_ff ? pend_val_ff : '0;
         rsp_none_in = !pend_valid_ff;
         rsp_last_in = 1'b1;
      end
      rsp_valid_in = (shift_load || finish_load) ? 1'b1 : (rsp_valid_ff && !out_ready);
   end

   always_comb begin
      out_valid = rsp_valid_ff;
      out_index = rsp_idx_ff;
      out_value = rsp_val_ff;
      out_none  = rsp_none_ff;
      out_last  = rsp_last_ff;
   end

   // store write and registered read
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[AW'(pop_index)] <= pop_value & VAL_KEEP;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= B_IDLE;
         b_valid_ff    <= 1'b0;
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         b_valid_ff    <= b_valid_in;
         pend_valid_ff <= pend_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      q_ctrl_ff     <= q_ctrl_in;
      centre_idx_ff <= centre_idx_in;
      centre_val_ff <= centre_val_in;
      slot_ff       <= slot_in;
      b_idx_ff      <= b_idx_in;
      pend_idx_ff   <= pend_idx_in;
      pend_val_ff   <= pend_val_in;
      rsp_idx_ff    <= rsp_idx_in;
      rsp_val_ff    <= rsp_val_in;
      rsp_none_ff   <= rsp_none_in;
      rsp_last_ff   <= rsp_last_in;
   end

endmodule

`default_nettype wire

/* hdl/voxel_neighbour_enumerator.sv */
// The front part's index divider works on a new query while the back part walks the 26
// slots of an earlier one, so the back part's walk sets the query rate. A response stall
// holds the walk.
// Reset clears control state and loads the register defaults; the voxel store
// is not cleared and reads as undefined until written.
// ----------------------------------------------------------------------------
// voxel_neighbour_enumerator
// 3D voxel store with face, edge, corner and eight-plus-two neighbour
// enumeration, range and centre comparison filtering.
// ----------------------------------------------------------------------------
`default_nettype none

module voxel_neighbour_enumerator
   import vne_pkg::*;
#(
   parameter int MAX_VOXELS = MAX_VOXELS_DEF,
   parameter int VALUE_BITS = VALUE_BITS_DEF,
   localparam int REQ_DW    = ((IDX_BITS + VALUE_BITS + 7) / 8) * 8,
   localparam int RSP_DW    = ((IDX_BITS + VALUE_BITS + 7) / 8) * 8
)
(
   input  wire                       clock,
   input  wire                       reset,
   input  wire                       req_tvalid,
   output logic                      req_tready,
   input  wire  [REQ_DW-1:0]         req_tdata,   // voxel_index, voxel_value
   input  wire  [1:0]                req_tuser,   // cmd
   output logic                      rsp_tvalid,
   input  wire                       rsp_tready,
   output logic [RSP_DW-1:0]         rsp_tdata,   // neighbour_index, neighbour_value
   output logic                      rsp_tuser,   // none_found
   output logic                      rsp_tlast,
   input  wire                       csr_wen,
   input  wire  [CSR_INDEX_BITS-1:0] csr_index,
   input  wire  [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int Q_W = $bits(q_ctrl_type) + IDX_BITS + VALUE_BITS;

   cfg_type                 cfg_ff, cfg_in;
   logic [DXY_BITS-1:0]     dxy_ff;
   logic [TOTAL_BITS-1:0]   total_ff;

   logic                    push_valid, push_ready;
   q_ctrl_type              push_ctrl;
   logic [IDX_BITS-1:0]     push_index;
   logic [VALUE_BITS-1:0]   push_value;
   logic                    pop_valid, pop_ready;
   q_ctrl_type              pop_ctrl;
   logic [IDX_BITS-1:0]     pop_index;
   logic [VALUE_BITS-1:0]   pop_value;
   logic [Q_W-1:0]          pop_data;
   logic [IDX_BITS-1:0]     out_index;
   logic [VALUE_BITS-1:0]   out_value;

   // register writes
   always_comb begin
      cfg_in = cfg_ff;
      if (csr_wen) begin
         unique case (csr_index)
            CSR_DIM_X:        cfg_in.dim_x        = csr_wdata[DIM_BITS-1:0];
            CSR_DIM_Y:        cfg_in.dim_y        = csr_wdata[DIM_BITS-1:0];
            CSR_DIM_Z:        cfg_in.dim_z        = csr_wdata[DIM_BITS-1:0];
            CSR_CONNECTIVITY: cfg_in.connectivity = conn_type'(csr_wdata[1:0]);
            CSR_SLICES_ONLY:  cfg_in.slices_only  = csr_wdata[0];
            CSR_RANGE_MIN:    cfg_in.range_min    = csr_wdata[RANGE_BITS-1:0];
            CSR_RANGE_MAX:    cfg_in.range_max    = csr_wdata[RANGE_BITS-1:0];
            default:          cfg_in              = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.dim_x        <= 5'd16;
         cfg_ff.dim_y        <= 5'd16;
         cfg_ff.dim_z        <= 5'd16;
         cfg_ff.connectivity <= CONN_CORNER;
         cfg_ff.slices_only  <= 1'b0;
         cfg_ff.range_min    <= '0;
         cfg_ff.range_max    <= '1;
      end else begin
         cfg_ff <= cfg_in;
      end
      // plane size and volume, one multiply per stage
      dxy_ff   <= DXY_BITS'({5'b0, cfg_ff.dim_x} * {5'b0, cfg_ff.dim_y});
      total_ff <= TOTAL_BITS'({5'b0, dxy_ff} * {10'b0, cfg_ff.dim_z});
   end

   vne_front #(
      .VALUE_BITS (VALUE_BITS),
      .MAX_VOXELS (MAX_VOXELS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .in_valid   (req_tvalid),
      .in_ready   (req_tready),
      .in_cmd     (cmd_type'(req_tuser)),
      .in_index   (req_tdata[IDX_BITS-1:0]),
      .in_value   (req_tdata[IDX_BITS+VALUE_BITS-1:IDX_BITS]),
      .cfg        (cfg_ff),
      .total      (total_ff),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_ctrl  (push_ctrl),
      .push_index (push_index),
      .push_value (push_value)
   );

   vne_fifo #(
      .WIDTH (Q_W)
   ) u_fifo (
      .clock    (clock),
      .reset    (reset),
      .wr_valid (push_valid),
      .wr_ready (push_ready),
      .wr_data  ({push_ctrl, push_index, push_value}),
      .rd_valid (pop_valid),
      .rd_ready (pop_ready),
      .rd_data  (pop_data)
   );

   // unpack queue entry
   always_comb begin
      pop_value = pop_data[VALUE_BITS-1:0];
      pop_index = pop_data[IDX_BITS+VALUE_BITS-1:VALUE_BITS];
      pop_ctrl  = q_ctrl_type'(pop_data[Q_W-1:IDX_BITS+VALUE_BITS]);
   end

   vne_back #(
      .MAX_VOXELS (MAX_VOXELS),
      .VALUE_BITS (VALUE_BITS)
   ) u_back (
      .clock     (clock),
      .reset     (reset),
      .pop_valid (pop_valid),
      .pop_ready (pop_ready),
      .pop_ctrl  (pop_ctrl),
      .pop_index (pop_index),
      .pop_value (pop_value),
      .cfg       (cfg_ff),
      .dxy       (dxy_ff),
      .out_valid (rsp_tvalid),
      .out_ready (rsp_tready),
      .out_index (out_index),
      .out_value (out_value),
      .out_none  (rsp_tuser),
      .out_last  (rsp_tlast)
   );

   assign rsp_tdata = RSP_DW'({out_value, out_index});

endmodule

`default_nettype wire

/* bench/tb_voxel_neighbour_enumerator.sv */
// ----------------------------------------------------------------------------
// tb_voxel_neighbour_enumerator
// Self-checking bench for the voxel neighbour enumerator. A short stimulus
// table covers the volume corners, every request kind and the degenerate
// volume, slice and range settings. It is followed by random phases, each
// with its own register settings. Every response is checked against a
// neighbour predictor that keeps its own copy of the voxel store and the
// registers. Both streams idle at random, and once the response side holds
// off long enough to back the block up.
// ----------------------------------------------------------------------------

module tb_voxel_neighbour_enumerator
   import vne_pkg::*;
();

   timeunit 1ns;
   timeprecision 1ps;

   localparam int DATA_W          = 32;
   localparam int VOXEL_COUNT     = 4096;
   localparam int MOST_RESULTS    = 26;
   localparam int SETTLE_CYCLES   = 48;
   localparam int LONG_STALL      = 300;
   localparam int PHASES          = 8;
   // requests per phase, the writes that prepare a query included
   localparam int ITEMS_PER_PHASE = 34;
   localparam int CYCLE_LIMIT     = 500000;
   localparam int PRINT_LIMIT     = 50;
   localparam int PLAN_ROWS       = 38;

   // one expected response
   typedef struct packed {
      logic [11:0] index;
      logic [15:0] value;
      logic        none_found;
      logic        last;
   } nbr_result_type;

   // one row of the directed table: a register write or a request
   typedef struct packed {
      logic        is_csr;
      logic [2:0]  csr_sel;
      logic [15:0] csr_data;
      cmd_type     cmd;
      logic [11:0] index;
      logic [15:0] value;
      logic        typed_none;
   } plan_row_type;

   logic              clock      = 1'b0;
   logic              reset      = 1'b1;
   logic              req_tvalid = 1'b0;
   logic              req_tready;
   logic [DATA_W-1:0] req_tdata  = '0;   // voxel_index, voxel_value
   logic [1:0]        req_tuser  = '0;   // cmd
   logic              rsp_tvalid;
   logic              rsp_tready;
   logic [DATA_W-1:0] rsp_tdata;         // neighbour_index, neighbour_value
   logic              rsp_tuser;         // none_found
   logic              rsp_tlast;
   logic              csr_wen    = 1'b0;
   logic [2:0]        csr_index  = '0;
   logic [15:0]       csr_wdata  = '0;

   // predictor state
   logic [15:0]     voxel_shadow [VOXEL_COUNT];
   bit              voxel_written [VOXEL_COUNT];
   cfg_type         shadow_cfg;
   nbr_result_type  pending_neighbours [$];

   // centre of the query being enumerated
   int           geo_x, geo_y, geo_z;
   int           centre_x, centre_y, centre_z, centre_index;
   logic [15:0]  centre_value;
   cmd_type      query_kind;
   int           found;

   int           mismatch_count = 0;
   int           cycle_count    = 0;
   int           request_count  = 0;
   bit           quiet_phase    = 1'b0;
   bit           stall_armed    = 1'b0;
   bit           stall_done     = 1'b0;
   int           stall_left     = 0;

   // directed table: corners of the full volume, then a 2x2x2 volume for the
   // outside-centre, slice, empty-range and bad-volume cases
   plan_row_type directed_plan [PLAN_ROWS] = '{
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_WRITE,   12'd4095, 16'hFFFF, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_GREATER, 12'd4095, 16'hA5A5, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_SMALLER, 12'd0,    16'hFFFF, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd2730, 16'h5555, 1'b0},
      '{1'b1, CSR_DIM_X,        16'd2,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_Y,        16'd2,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_Z,        16'd2,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd8,    16'h0000, 1'b1},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_SMALLER, 12'd4095, 16'h0000, 1'b1},
      '{1'b1, CSR_SLICES_ONLY,  16'd1,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_CONNECTIVITY, 16'd0,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd3,    16'h0000, 1'b1},
      '{1'b1, CSR_CONNECTIVITY, 16'd3,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_GREATER, 12'd0,    16'h0000, 1'b1},
      '{1'b1, CSR_CONNECTIVITY, 16'd1,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd5,    16'h0000, 1'b0},
      '{1'b1, CSR_CONNECTIVITY, 16'd2,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_SMALLER, 12'd6,    16'h0000, 1'b0},
      '{1'b1, CSR_SLICES_ONLY,  16'd0,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_GREATER, 12'd7,    16'h0000, 1'b0},
      '{1'b1, CSR_RANGE_MIN,    16'd9,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_RANGE_MAX,    16'd3,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_SMALLER, 12'd7,    16'h0000, 1'b1},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_GREATER, 12'd0,    16'h0000, 1'b1},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd7,    16'h0000, 1'b0},
      '{1'b1, CSR_RANGE_MIN,    16'd0,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_RANGE_MAX,    16'hFFFF,  CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_X,        16'd0,     CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_ALL,     12'd0,    16'h0000, 1'b1},
      '{1'b1, CSR_DIM_X,        16'd31,    CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_Y,        16'd31,    CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_Z,        16'd16,    CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_SMALLER, 12'd5,    16'h0000, 1'b1},
      '{1'b1, CSR_DIM_X,        16'd16,    CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b1, CSR_DIM_Y,        16'd16,    CMD_WRITE,   12'd0,    16'h0000, 1'b0},
      '{1'b0, CSR_DIM_X,        16'd0,     CMD_GREATER, 12'd4095, 16'h0000, 1'b0}
   };

   voxel_neighbour_enumerator DUT (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tuser  (rsp_tuser),
      .rsp_tlast  (rsp_tlast),
      .csr_wen    (csr_wen),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   // 4 ns clock
   always begin
      #2 clock = 1'b1;
      #2 clock = 1'b0;
   end

   task automatic report_mismatch(input string line);
      mismatch_count++;
      if (mismatch_count <= PRINT_LIMIT)
         $display("%s", line);
   endtask

   // one neighbour offset from the centre: bounds, range and ordering filters
   function automatic void consider(input int ox, input int oy, input int oz);
      int             x, y, z, nidx;
      logic [15:0]    v;
      bit             below, above;
      nbr_result_type r;
      x = centre_x + ox;
      y = centre_y + oy;
      z = centre_z + oz;
      if (x < 0 || y < 0 || z < 0 || x >= geo_x || y >= geo_y || z >= geo_z)
         return;
      nidx = (z * geo_y + y) * geo_x + x;
      if (nidx >= VOXEL_COUNT)
         return;
      v = voxel_shadow[nidx];
      if (query_kind != CMD_ALL) begin
         if (v < shadow_cfg.range_min || v > shadow_cfg.range_max)
            return;
         // equal values are ordered by linear index
         below = (v < centre_value) || (v == centre_value && nidx < centre_index);
         above = (v > centre_value) || (v == centre_value && nidx > centre_index);
         if (query_kind == CMD_SMALLER && !below)
            return;
         if (query_kind == CMD_GREATER && !above)
            return;
      end
      if (found < MOST_RESULTS) begin
         r.index      = nidx[11:0];
         r.value      = v;
         r.none_found = 1'b0;
         r.last       = 1'b0;
         pending_neighbours.push_back(r);
         found++;
      end
   endfunction

   // four face or four diagonal offsets in walk order at one z offset
   function automatic void walk_ring(input bit diagonal, input int oz);
      for (int k = 0; k < 4; k++) begin
         if (diagonal)
            consider((k % 2) ? 1 : -1, (k / 2) ? 1 : -1, oz);
         else
            consider(k == 1 ? -1 : (k == 2 ? 1 : 0), k == 0 ? -1 : (k == 3 ? 1 : 0), oz);
      end
   endfunction

   // expected responses of one query
   function automatic void enumerate_neighbours(input cmd_type c, input logic [11:0] vi);
      int             total, ci;
      bit             edge_up, corner;
      nbr_result_type r;
      geo_x      = shadow_cfg.dim_x;
      geo_y      = shadow_cfg.dim_y;
      geo_z      = shadow_cfg.dim_z;
      total      = geo_x * geo_y * geo_z;
      ci         = vi;
      query_kind = c;
      found      = 0;
      edge_up    = shadow_cfg.connectivity == CONN_EDGE ||
                   shadow_cfg.connectivity == CONN_CORNER;
      corner     = shadow_cfg.connectivity == CONN_CORNER;
      if (total != 0 && total <= VOXEL_COUNT && ci < total) begin
         centre_index = ci;
         centre_value = voxel_shadow[ci];
         centre_x     = ci % geo_x;
         centre_y     = (ci / geo_x) % geo_y;
         centre_z     = ci / (geo_x * geo_y);
         if (shadow_cfg.slices_only) begin
            if (edge_up) begin
               walk_ring(1'b0, 0);
               if (corner)
                  walk_ring(1'b1, 0);
            end
         end else begin
            walk_ring(1'b0, 0);
            if (shadow_cfg.connectivity != CONN_FACE)
               walk_ring(1'b1, 0);
            consider(0, 0, -1);
            consider(0, 0, 1);
            if (edge_up) begin
               walk_ring(1'b0, -1);
               walk_ring(1'b0, 1);
            end
            if (corner) begin
               walk_ring(1'b1, -1);
               walk_ring(1'b1, 1);
            end
         end
      end
      if (found == 0) begin
         r = '0;
         r.none_found = 1'b1;
         pending_neighbours.push_back(r);
      end
      pending_neighbours[pending_neighbours.size() - 1].last = 1'b1;
   endfunction

   // mostly small values so that ties and range edges come up often
   function automatic logic [15:0] random_value();
      case ($urandom_range(3))
         0, 1:    return 16'($urandom_range(7));
         2:       return 16'($urandom());
         default: return 16'hFFFF - 16'($urandom_range(3));
      endcase
   endfunction

   function automatic logic [4:0] pick_dim();
      int r;
      r = $urandom_range(99);
      if (r < 70)
         return 5'($urandom_range(5, 2));
      else if (r < 85)
         return 5'd1;
      else if (r < 95)
         return 5'($urandom_range(16, 6));
      else
         return 5'd16;
   endfunction

   // offer one request, with random idle cycles, and predict on acceptance
   task automatic put_request(input cmd_type c, input logic [11:0] vi,
                              input logic [15:0] vv, input bit typed_none);
      nbr_result_type r;
      @(negedge clock);
      while (!quiet_phase && $urandom_range(99) < 9) begin
         req_tvalid = 1'b0;
         @(negedge clock);
      end
      req_tvalid = 1'b1;
      req_tuser  = c;
      req_tdata  = {4'b0, vv, vi};
      do @(posedge clock); while (!req_tready);
      request_count++;
      if (c == CMD_WRITE) begin
         voxel_shadow[vi]  = vv;
         voxel_written[vi] = 1'b1;
      end else if (typed_none) begin
         r = '0;
         r.none_found = 1'b1;
         r.last       = 1'b1;
         pending_neighbours.push_back(r);
      end else begin
         enumerate_neighbours(c, vi);
      end
   endtask

   // store a value in every unwritten voxel around a centre before querying it
   task automatic prepare_query(input logic [11:0] vi);
      int gx, gy, gz, ci, x, y, z, nidx;
      gx = shadow_cfg.dim_x;
      gy = shadow_cfg.dim_y;
      gz = shadow_cfg.dim_z;
      ci = vi;
      if (gx * gy * gz == 0 || gx * gy * gz > VOXEL_COUNT || ci >= gx * gy * gz)
         return;
      for (int dz = -1; dz <= 1; dz++)
         for (int dy = -1; dy <= 1; dy++)
            for (int dx = -1; dx <= 1; dx++) begin
               x = ci % gx + dx;
               y = (ci / gx) % gy + dy;
               z = ci / (gx * gy) + dz;
               if (x >= 0 && y >= 0 && z >= 0 && x < gx && y < gy && z < gz) begin
                  nidx = (z * gy + y) * gx + x;
                  if (nidx < VOXEL_COUNT && !voxel_written[nidx])
                     put_request(CMD_WRITE, nidx[11:0], random_value(), 1'b0);
               end
            end
   endtask

   task automatic write_register(input logic [2:0] sel, input logic [15:0] data);
      @(negedge clock);
      csr_wen   = 1'b1;
      csr_index = sel;
      csr_wdata = data;
      @(negedge clock);
      csr_wen   = 1'b0;
      case (sel)
         CSR_DIM_X:        shadow_cfg.dim_x        = data[4:0];
         CSR_DIM_Y:        shadow_cfg.dim_y        = data[4:0];
         CSR_DIM_Z:        shadow_cfg.dim_z        = data[4:0];
         CSR_CONNECTIVITY: shadow_cfg.connectivity = conn_type'(data[1:0]);
         CSR_SLICES_ONLY:  shadow_cfg.slices_only  = data[0];
         CSR_RANGE_MIN:    shadow_cfg.range_min    = data;
         CSR_RANGE_MAX:    shadow_cfg.range_max    = data;
         default: ;
      endcase
   endtask

   // block drained: nothing outstanding, then time for trailing writes
   task automatic wait_idle();
      @(negedge clock);
      req_tvalid = 1'b0;
      while (pending_neighbours.size() != 0)
         @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   // response side: random holds, one long hold-off, a quiet phase
   initial begin
      rsp_tready = 1'b0;
      forever begin
         @(negedge clock);
         if (stall_left != 0) begin
            stall_left--;
            rsp_tready = 1'b0;
         end else if (stall_armed && !stall_done && rsp_tvalid) begin
            stall_left = LONG_STALL;
            stall_done = 1'b1;
            rsp_tready = 1'b0;
         end else begin
            rsp_tready = quiet_phase || ($urandom_range(99) >= 9);
         end
      end
   end

   // compare each accepted response with the oldest expectation
   always @(posedge clock) begin : check_responses
      nbr_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_neighbours.size() == 0) begin
            report_mismatch($sformatf("unexpected response idx %0d val %0d none %0b last %0b",
                                      rsp_tdata[11:0], rsp_tdata[27:12], rsp_tuser, rsp_tlast));
         end else begin
            want = pending_neighbours.pop_front();
            if (rsp_tdata[11:0] !== want.index || rsp_tdata[27:12] !== want.value ||
                rsp_tuser !== want.none_found || rsp_tlast !== want.last)
               report_mismatch($sformatf(
                  "response idx %0d val %0d none %0b last %0b, wanted %0d %0d %0b %0b",
                  rsp_tdata[11:0], rsp_tdata[27:12], rsp_tuser, rsp_tlast,
                  want.index, want.value, want.none_found, want.last));
         end
      end
   end

   // watchdog
   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("voxel_neighbour_enumerator: mismatch");
      $finish;
   end

   // stimulus
   initial begin
      plan_row_type row;
      bit           last_was_csr;
      int           total;
      int           phase_start;
      logic [4:0]   dx, dy, dz;
      conn_type     conn;
      logic         slices;
      logic [15:0]  rmin, rmax, wd, a, b;
      logic [11:0]  vi;

      shadow_cfg.dim_x        = 5'd16;
      shadow_cfg.dim_y        = 5'd16;
      shadow_cfg.dim_z        = 5'd16;
      shadow_cfg.connectivity = CONN_CORNER;
      shadow_cfg.slices_only  = 1'b0;
      shadow_cfg.range_min    = 16'h0000;
      shadow_cfg.range_max    = 16'hFFFF;
      last_was_csr            = 1'b0;

      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed table
      for (int i = 0; i < PLAN_ROWS; i++) begin
         row = directed_plan[i];
         if (row.is_csr) begin
            if (!last_was_csr)
               wait_idle();
            write_register(row.csr_sel, row.csr_data);
         end else begin
            if (row.cmd != CMD_WRITE && !row.typed_none)
               prepare_query(row.index);
            put_request(row.cmd, row.index, row.value, row.typed_none);
         end
         last_was_csr = row.is_csr;
      end

      // random phases, each with fresh register settings
      for (int phase = 0; phase < PHASES; phase++) begin
         wait_idle();
         case (phase)
            0: begin dx = 5'd16; dy = 5'd16; dz = 5'd16; end
            1: begin dx = 5'd1;  dy = 5'd1;  dz = 5'd1;  end
            default: begin dx = pick_dim(); dy = pick_dim(); dz = pick_dim(); end
         endcase
         conn   = (phase == 0) ? CONN_CORNER : conn_type'((phase + 1) % 4);
         slices = (phase == 4 || phase == 5);
         a = 16'($urandom_range(8));
         b = 16'($urandom_range(8));
         case (phase)
            6: begin rmin = 16'h0000; rmax = 16'h0000; end
            7: begin rmin = 16'hFFFF; rmax = 16'hFFFF; end
            default: begin
               case ($urandom_range(9))
                  0, 1, 2, 3: begin rmin = 16'h0000; rmax = 16'hFFFF; end
                  4, 5, 6:    begin rmin = (a < b) ? a : b; rmax = (a < b) ? b : a; end
                  7, 8:       begin rmin = 16'($urandom()); rmax = 16'($urandom()); end
                  default:    begin rmin = 16'hFFFF; rmax = 16'h0000; end
               endcase
            end
         endcase

         // spare upper bits of the narrow registers carry noise
         wd = 16'($urandom()); wd[4:0] = dx;     write_register(CSR_DIM_X, wd);
         wd = 16'($urandom()); wd[4:0] = dy;     write_register(CSR_DIM_Y, wd);
         wd = 16'($urandom()); wd[4:0] = dz;     write_register(CSR_DIM_Z, wd);
         wd = 16'($urandom()); wd[1:0] = conn;   write_register(CSR_CONNECTIVITY, wd);
         wd = 16'($urandom()); wd[0]   = slices; write_register(CSR_SLICES_ONLY, wd);
         write_register(CSR_RANGE_MIN, rmin);
         write_register(CSR_RANGE_MAX, rmax);

         quiet_phase = (phase == 2);
         stall_armed = (phase == 0);

         phase_start = request_count;
         while (request_count - phase_start < ITEMS_PER_PHASE) begin
            total = int'(shadow_cfg.dim_x) * int'(shadow_cfg.dim_y) * int'(shadow_cfg.dim_z);
            if (total != 0 && total <= VOXEL_COUNT && $urandom_range(99) < 88)
               vi = 12'($urandom_range(total - 1));
            else
               vi = 12'($urandom());
            if ($urandom_range(99) < 25) begin
               put_request(CMD_WRITE, vi, random_value(), 1'b0);
            end else begin
               prepare_query(vi);
               put_request(cmd_type'($urandom_range(3, 1)), vi, 16'($urandom()), 1'b0);
            end
         end
      end

      wait_idle();
      if (mismatch_count == 0)
         $display("voxel_neighbour_enumerator: match");
      else
         $display("voxel_neighbour_enumerator: mismatch");
      $finish;
   end

endmodule

/* voxel_neighbour_enumerator.f */
hdl/vne_pkg.sv
hdl/vne_front.sv
hdl/vne_fifo.sv
hdl/vne_back.sv
hdl/voxel_neighbour_enumerator.sv
bench/tb_voxel_neighbour_enumerator.sv
